// ----- rtl/core/rrpf_pkg.sv -----
// ----------------------------------------------------------------------------
// rrpf_pkg
// shared types, field widths and codes of the reservable resource pool block
// ----------------------------------------------------------------------------
package rrpf_pkg;

    // field widths of one request and one result
    localparam int ACT_W  = 2;
    localparam int REQ_W  = 4;
    localparam int KIND_W = 2;
    localparam int STAT_W = 4;
    localparam int CNT_W  = 4;
    localparam int IN_W   = 8;
    localparam int OUT_W  = 24;

    // request actions
    localparam logic [ACT_W-1:0] ACT_USE     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_USED_RESERVED = 4'd0;
    localparam logic [STAT_W-1:0] STAT_USED_FREE     = 4'd1;
    localparam logic [STAT_W-1:0] STAT_QUEUED        = 4'd2;
    localparam logic [STAT_W-1:0] STAT_QUEUE_FULL    = 4'd3;
    localparam logic [STAT_W-1:0] STAT_RESERVED      = 4'd4;
    localparam logic [STAT_W-1:0] STAT_RES_REFUSED   = 4'd5;
    localparam logic [STAT_W-1:0] STAT_RELEASED      = 4'd6;
    localparam logic [STAT_W-1:0] STAT_HANDED_OVER   = 4'd7;
    localparam logic [STAT_W-1:0] STAT_RELEASE_ERR   = 4'd8;

    // controller states
    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } rrpf_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch request beat, launch memory reads
        logic exec;      // apply request to pool state, load result
    } rrpf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new result
    } rrpf_sts_t;

endpackage

// ----- rtl/core/rrpf_ram.sv -----
// ----------------------------------------------------------------------------
// rrpf_ram
// generic single write port ram with registered read and read enable
// ----------------------------------------------------------------------------
module rrpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/rrpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrpf_ctrl
// request sequencer: accept a beat, then execute it once the result slot frees
// ----------------------------------------------------------------------------
module rrpf_ctrl
    import rrpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  rrpf_sts_t sts,
    output rrpf_cmd_t cmd
);

    rrpf_state_t state_reg;
    rrpf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait here while the previous result is still unclaimed
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/rrpf_dp.sv -----
// ----------------------------------------------------------------------------
// rrpf_dp
// pool counters, reservation slots, wait queue memory and result register
// ----------------------------------------------------------------------------
module rrpf_dp
    import rrpf_pkg::*;
#(
    parameter int TYPES       = 4,
    parameter int UNITS       = 2,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IN_W-1:0]  s_tdata,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  rrpf_cmd_t        cmd,
    output rrpf_sts_t        sts
);

    localparam int TIW = (TYPES > 1) ? $clog2(TYPES) : 1;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int FW  = $clog2(UNITS + 1);
    localparam int SW  = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int WQD = TYPES * QUEUE_DEPTH;
    localparam int WAW = (WQD > 1) ? $clog2(WQD) : 1;
    localparam int RW  = UNITS * REQ_W;

    // per pool state
    logic [FW-1:0]    free_reg  [TYPES];
    logic [FW-1:0]    use_reg   [TYPES];
    logic [CW-1:0]    cnt_reg   [TYPES];
    logic [PW-1:0]    head_reg  [TYPES];
    logic [PW-1:0]    tail_reg  [TYPES];
    logic [UNITS-1:0] rvld_reg  [TYPES];

    // captured request
    logic [ACT_W-1:0]  act_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [KIND_W-1:0] kind_reg;

    // result register
    logic              mvalid_reg;
    logic              mvalid_next;
    logic [OUT_W-1:0]  out_reg;

    // memory ports
    logic [TIW-1:0]   in_tidx;
    logic [WAW-1:0]   wq_raddr;
    logic [WAW-1:0]   wq_waddr;
    logic [REQ_W-1:0] wq_rdata;
    logic             wq_we;
    logic [RW-1:0]    row_rdata;
    logic             rv_we;

    // execute stage
    logic [TIW-1:0]    tidx;
    logic              kind_ok;
    logic [FW-1:0]     f;
    logic [FW-1:0]     u;
    logic [CW-1:0]     c;
    logic [PW-1:0]     h;
    logic [PW-1:0]     t;
    logic [UNITS-1:0]  vld;
    logic              hit_any;
    logic [SW-1:0]     hit_idx;
    logic              emp_any;
    logic [SW-1:0]     emp_idx;
    logic [FW-1:0]     f_n;
    logic [FW-1:0]     u_n;
    logic [CW-1:0]     c_n;
    logic [PW-1:0]     h_n;
    logic [PW-1:0]     t_n;
    logic [UNITS-1:0]  vld_n;
    logic [RW-1:0]     row_n;
    logic [STAT_W-1:0] status;
    logic              wv;
    logic [REQ_W-1:0]  wr;
    logic [CNT_W-1:0]  free_left;
    logic [CNT_W-1:0]  waiting_left;

    // read addresses come straight from the incoming beat
    assign in_tidx  = TIW'(s_tdata[IN_W-1 -: KIND_W]);
    assign wq_raddr = WAW'(32'(in_tidx) * QUEUE_DEPTH + 32'(head_reg[in_tidx]));

    assign tidx     = TIW'(kind_reg);
    assign kind_ok  = (32'(kind_reg) < 32'(TYPES));
    assign f        = free_reg[tidx];
    assign u        = use_reg[tidx];
    assign c        = cnt_reg[tidx];
    assign h        = head_reg[tidx];
    assign t        = tail_reg[tidx];
    assign vld      = rvld_reg[tidx];
    assign wq_waddr = WAW'(32'(tidx) * QUEUE_DEPTH + 32'(t));

    rrpf_ram #(
        .WIDTH (REQ_W),
        .DEPTH (WQD)
    ) u_wait_ram (
        .clk   (clk),
        .we    (wq_we),
        .waddr (wq_waddr),
        .wdata (req_reg),
        .re    (cmd.capture),
        .raddr (wq_raddr),
        .rdata (wq_rdata)
    );

    rrpf_ram #(
        .WIDTH (RW),
        .DEPTH (TYPES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (rv_we),
        .waddr (tidx),
        .wdata (row_n),
        .re    (cmd.capture),
        .raddr (in_tidx),
        .rdata (row_rdata)
    );

    // lowest matching reservation and lowest empty slot
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        emp_any = 1'b0;
        emp_idx = '0;
        for (int s = UNITS - 1; s >= 0; s--)
        begin
            if (vld[s] && (row_rdata[s*REQ_W +: REQ_W] == req_reg))
            begin
                hit_any = 1'b1;
                hit_idx = SW'(s);
            end
            if (!vld[s])
            begin
                emp_any = 1'b1;
                emp_idx = SW'(s);
            end
        end
    end

    always_comb
    begin
        f_n    = f;
        u_n    = u;
        c_n    = c;
        h_n    = h;
        t_n    = t;
        vld_n  = vld;
        row_n  = row_rdata;
        rv_we  = 1'b0;
        wq_we  = 1'b0;
        wv     = 1'b0;
        wr     = '0;
        status = STAT_RELEASE_ERR;
        if (!kind_ok)
        begin
            if (act_reg == ACT_USE)
            begin
                status = STAT_QUEUE_FULL;
            end
            else if (act_reg == ACT_RESERVE)
            begin
                status = STAT_RES_REFUSED;
            end
        end
        else
        begin
            unique case (act_reg)
                ACT_USE:
                begin
                    if (hit_any)
                    begin
                        vld_n[hit_idx] = 1'b0;
                        u_n            = u + 1'b1;
                        status         = STAT_USED_RESERVED;
                    end
                    else if ((c == '0) && (f != '0))
                    begin
                        f_n    = f - 1'b1;
                        u_n    = u + 1'b1;
                        status = STAT_USED_FREE;
                    end
                    else if (c < CW'(QUEUE_DEPTH))
                    begin
                        wq_we  = cmd.exec;
                        t_n    = (t == PW'(QUEUE_DEPTH - 1)) ? '0 : t + 1'b1;
                        c_n    = c + 1'b1;
                        status = STAT_QUEUED;
                    end
                    else
                    begin
                        status = STAT_QUEUE_FULL;
                    end
                end
                ACT_RESERVE:
                begin
                    if ((f != '0) && emp_any)
                    begin
                        vld_n[emp_idx]                 = 1'b1;
                        row_n[emp_idx*REQ_W +: REQ_W]  = req_reg;
                        rv_we                          = cmd.exec;
                        f_n                            = f - 1'b1;
                        status                         = STAT_RESERVED;
                    end
                    else
                    begin
                        status = STAT_RES_REFUSED;
                    end
                end
                ACT_RELEASE:
                begin
                    if (u == '0)
                    begin
                        status = STAT_RELEASE_ERR;
                    end
                    else if (c != '0)
                    begin
                        // token passing: the unit goes to the queue head
                        wv     = 1'b1;
                        wr     = wq_rdata;
                        h_n    = (h == PW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
                        c_n    = c - 1'b1;
                        status = STAT_HANDED_OVER;
                    end
                    else
                    begin
                        if (f < FW'(UNITS))
                        begin
                            f_n = f + 1'b1;
                        end
                        u_n    = u - 1'b1;
                        status = STAT_RELEASED;
                    end
                end
                default:
                begin
                    status = STAT_RELEASE_ERR;
                end
            endcase
        end
    end

    assign free_left    = kind_ok ? CNT_W'(f_n) : '0;
    assign waiting_left = kind_ok ? CNT_W'(c_n) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TYPES; i++)
            begin
                free_reg[i] <= FW'(UNITS);
                use_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                rvld_reg[i] <= '0;
            end
        end
        else if (cmd.exec && kind_ok)
        begin
            free_reg[tidx] <= f_n;
            use_reg[tidx]  <= u_n;
            cnt_reg[tidx]  <= c_n;
            head_reg[tidx] <= h_n;
            tail_reg[tidx] <= t_n;
            rvld_reg[tidx] <= vld_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= s_tdata[ACT_W-1:0];
            req_reg  <= s_tdata[ACT_W +: REQ_W];
            kind_reg <= s_tdata[ACT_W + REQ_W +: KIND_W];
        end
        if (cmd.exec)
        begin
            out_reg <= {7'd0, waiting_left, free_left, wr, wv, status};
        end
    end

    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (cmd.exec)
        begin
            mvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg <= 1'b0;
        end
        else
        begin
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid     = mvalid_reg;
    assign m_tdata      = out_reg;
    assign sts.out_free = !mvalid_reg || m_tready;

endmodule

// ----- rtl/core/reservable_resource_pool_fifo_unit.sv -----
// ----------------------------------------------------------------------------
// reservable_resource_pool_fifo_unit
// counting semaphore pools with reservation slots and fifo wait queues
// ----------------------------------------------------------------------------
// usage:
// - requests arrive on the s_axis channel, one beat per request; every
//   request yields exactly one result beat on the m_axis channel
// - a request is latched in the accept cycle, which also launches the reads
//   of the wait queue memory (queue head) and the reservation slot row
// - the execute step applies the request to the pool counters and loads the
//   result register once the output register is free; it comes after the
//   accept step, as the registered read of the wait queue and slot memories
//   must come ahead of the read-modify-write; no new request is taken until
//   the execute step is done, and the result shows on m_axis from its register
// - while a result waits in the output register, the next request is still
//   taken; its execute step holds until the downstream side takes the result
// - reset clears every pool to all units free, nothing in use, empty queues
//   and no reservations; queue and slot memories need no clearing pass, as
//   every read of them is covered by a count or a valid bit
// - a resource_kind beyond the configured pool count changes nothing
// ----------------------------------------------------------------------------
module reservable_resource_pool_fifo_unit
    import rrpf_pkg::*;
#(
    parameter int TYPES       = 4,    // number of pools
    parameter int UNITS       = 2,    // units and reservation slots per pool
    parameter int QUEUE_DEPTH = 8     // wait queue entries per pool
) (
    input  logic             clk,
    input  logic             rst_n,
    // request beat
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // action[1:0], requester[5:2], resource_kind[7:6]
    // result beat
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // status[3:0], woken_valid[4],
                                             // woken_requester[8:5], free_left[12:9],
                                             // waiting_left[16:13], zero pad[23:17]
);

    rrpf_cmd_t cmd;
    rrpf_sts_t sts;

    // sequencer: one request in flight at a time
    rrpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // pool state, memories and the result register
    rrpf_dp #(
        .TYPES       (TYPES),
        .UNITS       (UNITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_axis_tdata),
        .m_tdata  (m_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
